### hw/rtl/itp_pkg.sv
// Shared types, codes and helpers for the infix-to-postfix converter.
// No dependencies; imported by the converter unit and the sequencer.
`default_nettype none

package itp_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 3;

  // Token kinds as they arrive on the input channel.
  typedef enum logic [2:0] {
    TK_NUMBER   = 3'd0,
    TK_OPERATOR = 3'd1,
    TK_LPAREN   = 3'd2,
    TK_RPAREN   = 3'd3,
    TK_END      = 3'd4
  } tok_kind_t;

  // Operator codes; the open parenthesis mark shares the stack encoding.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_POW   = 3'd4,
    OP_PAREN = 3'd5
  } op_code_t;

  // Error codes carried on a result.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_OPEN     = 2'd3
  } err_code_t;

  // One postfix result without its end-of-run mark.
  typedef struct packed {
    logic        is_op;
    logic [2:0]  op;
    logic [31:0] value;
    logic        neg;
    logic [1:0]  err;
  } result_t;

  // Stack memory access request from the sequencer.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  // Precedence of a stack entry; the parenthesis mark ranks lowest.
  function automatic logic [1:0] prio(input logic [ENTRY_W-1:0] e);
    logic [1:0] p;
    case (e) inside
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/itp_token_if.sv
// Input channel of the converter: one scanned token per request.
// Standalone interface with valid/ready handshake; no dependencies.
`default_nettype none

interface itp_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [2:0]  op_code;
  logic [31:0] number_value;

  modport source (output valid, output token_kind, output op_code,
                  output number_value, input ready);
  modport sink   (input valid, input token_kind, input op_code,
                  input number_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/itp_result_if.sv
// Output channel of the converter: one postfix result per request.
// Standalone interface with valid/ready handshake; no dependencies.
`default_nettype none

interface itp_result_if;
  logic        valid;
  logic        ready;
  logic        out_is_operator;
  logic [2:0]  out_op;
  logic [31:0] out_value;
  logic        out_negative;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output out_is_operator, output out_op,
                  output out_value, output out_negative, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_is_operator, input out_op,
                  input out_value, input out_negative, input error_code,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/infix_to_postfix_converter_unit.sv
// Infix-to-postfix converter: operator stack in a synchronous RAM, driven by
// a shunting-yard sequencer. Depends on itp_pkg, both channel interfaces,
// itp_stack_ram and itp_seq.
// A number passes through the staging register and then the output register;
// other requests read the stack through the registered RAM read and pop
// entries while the output can take them, and an error result is staged
// after them. One request is in work at a time, and output stalls hold the
// sequencer. Synchronous reset empties the stack and clears the parser state;
// the RAM is not cleared, since only entries below the count are read.
`default_nettype none

module infix_to_postfix_converter_unit
  import itp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  itp_token_if.sink    token_in,
  itp_result_if.source result_out
);

  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] rd_data;

  // Operator stack storage.
  itp_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // Parser sequencer and output register.
  itp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .token_in   (token_in),
    .result_out (result_out),
    .ram_req    (ram_req),
    .rd_data    (rd_data)
  );

endmodule

`default_nettype wire

### hw/rtl/itp_stack_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the operator stack; no package dependencies.
`default_nettype none

module itp_stack_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 3
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/itp_seq.sv
// Shunting-yard sequencer: token decode, stack pop loop, result staging and
// output register. Depends on itp_pkg and the two channel interfaces.
`default_nettype none

module itp_seq
  import itp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  itp_token_if.sink                token_in,
  itp_result_if.source             result_out,
  output ram_req_t                 ram_req,
  input  wire logic [ENTRY_W-1:0]  rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_PUSH,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    CLS_START,
    CLS_OPEN,
    CLS_OPERAND,
    CLS_OPERATOR
  } cls_t;

  state_t             state, state_next;
  cls_t               prev, prev_next;
  logic [2:0]         kind_q, kind_q_next;
  logic [2:0]         op_q, op_q_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [COUNT_W-1:0] rd_ptr;
  logic               neg_pend, neg_pend_next;
  logic               found, found_next;
  logic [1:0]         err_pend, err_pend_next;
  result_t            hold, hold_next;
  logic               hold_valid, hold_valid_next;
  result_t            out_res, out_res_next;
  logic               out_last, out_last_next;
  logic               out_valid, out_valid_next;
  logic               out_free;
  logic               emit;
  result_t            emit_res;
  logic               can_emit;

  assign out_free = !out_valid || result_out.ready;
  assign can_emit = !hold_valid || out_free;

  // Input and output handshake.
  assign token_in.ready             = (state == S_IDLE);
  assign result_out.valid           = out_valid;
  assign result_out.out_is_operator = out_res.is_op;
  assign result_out.out_op          = out_res.op;
  assign result_out.out_value       = out_res.value;
  assign result_out.out_negative    = out_res.neg;
  assign result_out.error_code      = out_res.err;
  assign result_out.last_of_run     = out_last;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next      = state;
    prev_next       = prev;
    kind_q_next     = kind_q;
    op_q_next       = op_q;
    count_next      = count;
    neg_pend_next   = neg_pend;
    found_next      = found;
    err_pend_next   = err_pend;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    out_res_next    = out_res;
    out_last_next   = out_last;
    out_valid_next  = out_valid && !result_out.ready;
    emit            = 1'b0;
    emit_res        = '0;
    ram_req         = '0;

    unique case (state)
      S_IDLE: begin
        if (token_in.valid) begin
          kind_q_next = token_in.token_kind;
          op_q_next   = token_in.op_code;
          found_next  = 1'b0;
          case (token_in.token_kind)
            TK_NUMBER: begin
              hold_next.is_op = 1'b0;
              hold_next.op    = '0;
              hold_next.value = token_in.number_value;
              hold_next.neg   = neg_pend;
              hold_next.err   = ERR_NONE;
              hold_valid_next = 1'b1;
              neg_pend_next   = 1'b0;
              prev_next       = CLS_OPERAND;
              state_next      = S_FLUSH;
            end
            TK_OPERATOR: begin
              if (token_in.op_code <= OP_POW) begin
                prev_next = CLS_OPERATOR;
                if (token_in.op_code == OP_SUB &&
                    (prev == CLS_START || prev == CLS_OPEN)) begin
                  // Unary minus: remembered for the next number.
                  neg_pend_next = 1'b1;
                end else if (count != '0) begin
                  ram_req.re = 1'b1;
                  state_next = S_CHECK;
                end else begin
                  state_next = S_PUSH;
                end
              end
            end
            TK_LPAREN: begin
              prev_next  = CLS_OPEN;
              state_next = S_PUSH;
            end
            TK_RPAREN: begin
              prev_next = CLS_OPERAND;
              if (count != '0) begin
                ram_req.re = 1'b1;
                state_next = S_CHECK;
              end else begin
                err_pend_next = ERR_CLOSE;
                state_next    = S_FLUSH;
              end
            end
            TK_END: begin
              neg_pend_next = 1'b0;
              prev_next     = CLS_START;
              if (count != '0) begin
                ram_req.re = 1'b1;
                state_next = S_CHECK;
              end else begin
                state_next = S_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // The top entry sits in rd_data; pop it or stop.
      S_CHECK: begin
        case (kind_q)
          TK_OPERATOR: begin
            if (prio(rd_data) >= prio(op_q)) begin
              if (can_emit) begin
                emit       = 1'b1;
                count_next = count - COUNT_W'(1);
                if (count_next != '0) begin
                  ram_req.re = 1'b1;
                end else begin
                  state_next = S_PUSH;
                end
              end
            end else begin
              state_next = S_PUSH;
            end
          end
          TK_RPAREN: begin
            if (rd_data == OP_PAREN) begin
              count_next = count - COUNT_W'(1);
              state_next = S_FLUSH;
            end else if (can_emit) begin
              emit       = 1'b1;
              count_next = count - COUNT_W'(1);
              if (count_next != '0) begin
                ram_req.re = 1'b1;
              end else begin
                err_pend_next = ERR_CLOSE;
                state_next    = S_FLUSH;
              end
            end
          end
          default: begin
            // End of expression: drain everything, dropping paren marks and flagging an open error.
            if (rd_data == OP_PAREN || can_emit) begin
              emit       = (rd_data != OP_PAREN);
              count_next = count - COUNT_W'(1);
              if (rd_data == OP_PAREN) begin
                found_next = 1'b1;
              end
              if (count_next != '0) begin
                ram_req.re = 1'b1;
              end else begin
                err_pend_next = (found || rd_data == OP_PAREN) ? ERR_OPEN : ERR_NONE;
                state_next    = S_FLUSH;
              end
            end
          end
        endcase
        emit_res.is_op = 1'b1;
        emit_res.op    = rd_data;
        emit_res.value = '0;
        emit_res.neg   = 1'b0;
        emit_res.err   = ERR_NONE;
      end

      // Push the operator or paren mark, or flag a full stack.
      S_PUSH: begin
        if (count < COUNT_W'(STACK_DEPTH)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = count[IDX_W-1:0];
          ram_req.wdata = (kind_q == TK_LPAREN) ? OP_PAREN : op_q;
          count_next    = count + COUNT_W'(1);
        end else begin
          err_pend_next = ERR_OVERFLOW;
        end
        state_next = S_FLUSH;
      end

      // Hand the staged result to the output register, then any error.
      S_FLUSH: begin
        if (hold_valid) begin
          if (out_free) begin
            out_res_next    = hold;
            out_last_next   = (err_pend == ERR_NONE);
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
          end
        end else if (err_pend != ERR_NONE) begin
          hold_next.is_op = 1'b0;
          hold_next.op    = '0;
          hold_next.value = '0;
          hold_next.neg   = 1'b0;
          hold_next.err   = err_pend;
          hold_valid_next = 1'b1;
          err_pend_next   = ERR_NONE;
        end else begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A new pop result moves the staged one out, which is not the last.
    if (emit) begin
      if (hold_valid) begin
        out_res_next   = hold;
        out_last_next  = 1'b0;
        out_valid_next = 1'b1;
      end
      hold_next       = emit_res;
      hold_valid_next = 1'b1;
    end

    // The read always targets the entry below the updated count.
    rd_ptr        = count_next - COUNT_W'(1);
    ram_req.raddr = rd_ptr[IDX_W-1:0];
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev       <= CLS_START;
      count      <= '0;
      neg_pend   <= 1'b0;
      found      <= 1'b0;
      err_pend   <= ERR_NONE;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      prev       <= prev_next;
      count      <= count_next;
      neg_pend   <= neg_pend_next;
      found      <= found_next;
      err_pend   <= err_pend_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
    kind_q   <= kind_q_next;
    op_q     <= op_q_next;
    hold     <= hold_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
  end

endmodule

`default_nettype wire
